@@ hw/rtl/sad_pkg.sv @@
// shared types and constants for the sprite attribute decoder
`timescale 1ns / 1ps

package sad_pkg;

    // cell size in pixels
    localparam int CELL_WIDTH  = 16;
    localparam int CELL_HEIGHT = 16;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_FLIP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLOUR_BANK = 2'd1;

    // decode constants
    localparam logic [10:0] X_OFFSET     = 11'd72;
    localparam logic [10:0] FLIP_X_BASE  = 11'(512 - CELL_WIDTH);
    localparam logic [10:0] FLIP_Y_BASE  = 11'(256 - CELL_HEIGHT);
    localparam logic [10:0] CELL_H_STEP  = 11'(CELL_HEIGHT);

    // cell sequence of one sprite
    typedef enum logic [2:0] {
        STEP_WIDE  = 3'd0,
        STEP_TALL1 = 3'd1,
        STEP_TALL2 = 3'd2,
        STEP_TALL3 = 3'd3,
        STEP_MAIN  = 3'd4
    } step_t;

    // decoded sprite entry passed from front to back
    typedef struct packed {
        logic [8:0]         code_main;
        logic [8:0]         code_alt;
        logic [5:0]         colour;
        logic               mirror_x;
        logic               mirror_y;
        logic signed [10:0] pos_x;
        logic signed [10:0] pos_y;
        logic               wide;
        logic               tall;
    } sad_desc_t;

endpackage

@@ hw/rtl/sprite_attribute_decoder_unit.sv @@
// top level of the sprite attribute decoder
`timescale 1ns / 1ps

// Sprite attribute decoder. Each four-byte sprite request (flags, inverted y,
// code, x) becomes one to five draw commands: a wide entry adds a cell below
// the main one, a tall entry adds three more, and the main cell comes last
// with last_cell set. The front end decodes a request in the cycle it is
// taken and accepts one per cycle while its queue (QUEUE_DEPTH entries) has
// room. The back end sends one command per cycle from a registered output
// while cmd_ready is high, one command per cell of a sprite; sustained
// throughput is set by that command stream. Configuration writes
// (screen flip, colour bank) are always accepted and must be made while the
// block is idle.
module sprite_attribute_decoder_unit #(
    parameter int QUEUE_DEPTH = sad_pkg::QUEUE_DEPTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sad_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            sprite_valid,
    output logic                            sprite_ready,
    input  logic [7:0]                      attr_flags,
    input  logic [7:0]                      raw_y,
    input  logic [7:0]                      raw_code,
    input  logic [7:0]                      raw_x,
    output logic                            cmd_valid,
    input  logic                            cmd_ready,
    output logic [9:0]                      tile_code,
    output logic [5:0]                      colour,
    output logic                            mirror_x,
    output logic                            mirror_y,
    output logic signed [10:0]              pos_x,
    output logic signed [10:0]              pos_y,
    output logic                            last_cell
);
    import sad_pkg::*;

    logic      push;
    logic      pop;
    logic      queue_full;
    logic      queue_not_empty;
    sad_desc_t push_desc;
    sad_desc_t head_desc;

    // decode and configuration
    sad_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sprite_valid (sprite_valid),
        .sprite_ready (sprite_ready),
        .attr_flags   (attr_flags),
        .raw_y        (raw_y),
        .raw_code     (raw_code),
        .raw_x        (raw_x),
        .queue_full   (queue_full),
        .push         (push),
        .desc         (push_desc)
    );

    // decoupling queue
    sad_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_desc)
    );

    // cell sequencing and command output
    sad_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (queue_not_empty),
        .head       (head_desc),
        .pop        (pop),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .tile_code  (tile_code),
        .colour     (colour),
        .mirror_x   (mirror_x),
        .mirror_y   (mirror_y),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .last_cell  (last_cell)
    );

endmodule

@@ hw/rtl/sad_front.sv @@
// front end: configuration registers and decode of sprite entries
`timescale 1ns / 1ps

module sad_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sad_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sad_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           sprite_valid,
    output logic                           sprite_ready,
    input  logic [7:0]                     attr_flags,
    input  logic [7:0]                     raw_y,
    input  logic [7:0]                     raw_code,
    input  logic [7:0]                     raw_x,
    input  logic                           queue_full,
    output logic                           push,
    output sad_pkg::sad_desc_t             desc
);
    import sad_pkg::*;

    logic       screen_flip_reg;
    logic       screen_flip_next;
    logic [1:0] colour_bank_reg;
    logic [1:0] colour_bank_next;

    logic [8:0]  code;
    logic [10:0] x_base;
    logic [10:0] y_base;
    logic        wide;
    logic        tall;
    logic        my_eff;

    // configuration writes, taken at once
    assign cfg_ready = 1'b1;

    always_comb
    begin
        screen_flip_next = screen_flip_reg;
        colour_bank_next = colour_bank_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SCREEN_FLIP: screen_flip_next = cfg_data[0];
                REG_COLOUR_BANK: colour_bank_next = cfg_data[1:0];
                default:
                begin
                    screen_flip_next = screen_flip_reg;
                    colour_bank_next = colour_bank_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_flip_reg <= 1'b0;
            colour_bank_reg <= 2'd0;
        end
        else
        begin
            screen_flip_reg <= screen_flip_next;
            colour_bank_reg <= colour_bank_next;
        end
    end

    // request handshake into the queue
    assign sprite_ready = !queue_full;
    assign push         = sprite_valid && !queue_full;

    // field extraction
    assign code   = {attr_flags[5], raw_code};
    assign wide   = attr_flags[3];
    assign tall   = attr_flags[4];
    assign x_base = {2'b00, raw_x, 1'b0} + X_OFFSET;
    assign y_base = {3'b000, raw_y ^ 8'hFF};
    assign my_eff = attr_flags[6] ^ screen_flip_reg;

    // position, mirrors and codes
    always_comb
    begin
        desc.mirror_x = attr_flags[7] ^ screen_flip_reg;
        desc.mirror_y = my_eff;
        desc.wide     = wide;
        desc.tall     = tall;
        desc.colour   = {colour_bank_reg, code[3], code[7], attr_flags[2:1]};
        if (screen_flip_reg)
        begin
            desc.pos_x = FLIP_X_BASE - x_base;
            desc.pos_y = FLIP_Y_BASE - y_base - (wide ? CELL_H_STEP : 11'd0);
        end
        else
        begin
            desc.pos_x = x_base;
            desc.pos_y = y_base;
        end
        desc.code_main = code;
        desc.code_alt  = code;
        if (wide)
        begin
            desc.code_main[4] = my_eff;
            desc.code_alt[4]  = !my_eff;
        end
    end

endmodule

@@ hw/rtl/sad_queue.sv @@
// small queue of decoded sprite entries between front and back
`timescale 1ns / 1ps

module sad_queue #(
    parameter int DEPTH = sad_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  sad_pkg::sad_desc_t push_desc,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output sad_pkg::sad_desc_t head
);
    import sad_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sad_desc_t        entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

@@ hw/rtl/sad_back.sv @@
// back end: walks the cells of one sprite and holds the draw command register
`timescale 1ns / 1ps

module sad_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  sad_pkg::sad_desc_t head,
    output logic               pop,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output logic [9:0]         tile_code,
    output logic [5:0]         colour,
    output logic               mirror_x,
    output logic               mirror_y,
    output logic signed [10:0] pos_x,
    output logic signed [10:0] pos_y,
    output logic               last_cell
);
    import sad_pkg::*;

    logic  active_reg;
    logic  active_next;
    step_t step_reg;
    step_t step_next;
    step_t cur_step;
    logic  load;

    logic [1:0] y_mul;
    logic [1:0] code_add;
    logic       is_main;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [9:0]         out_code_reg;
    logic [5:0]         out_colour_reg;
    logic               out_mx_reg;
    logic               out_my_reg;
    logic signed [10:0] out_x_reg;
    logic signed [10:0] out_y_reg;
    logic               out_last_reg;

    // step of the cell about to be sent
    always_comb
    begin
        if (active_reg)
            cur_step = step_reg;
        else if (head.wide)
            cur_step = STEP_WIDE;
        else if (head.tall)
            cur_step = STEP_TALL1;
        else
            cur_step = STEP_MAIN;
    end

    // output slot free or draining this cycle
    assign load = head_valid && (!out_valid_reg || cmd_ready);
    assign pop  = load && is_main;

    // per-step offsets
    always_comb
    begin
        case (cur_step)
            STEP_WIDE:
            begin
                y_mul = 2'd1; code_add = 2'd0; is_main = 1'b0;
            end
            STEP_TALL1:
            begin
                y_mul = 2'd1; code_add = 2'd1; is_main = 1'b0;
            end
            STEP_TALL2:
            begin
                y_mul = 2'd2; code_add = 2'd2; is_main = 1'b0;
            end
            STEP_TALL3:
            begin
                y_mul = 2'd3; code_add = 2'd3; is_main = 1'b0;
            end
            STEP_MAIN:
            begin
                y_mul = 2'd0; code_add = 2'd0; is_main = 1'b1;
            end
            default:
            begin
                y_mul = 2'd0; code_add = 2'd0; is_main = 1'b1;
            end
        endcase
    end

    // next step of the sequence
    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        if (load)
        begin
            active_next = !is_main;
            case (cur_step)
                STEP_WIDE:  step_next = head.tall ? STEP_TALL1 : STEP_MAIN;
                STEP_TALL1: step_next = STEP_TALL2;
                STEP_TALL2: step_next = STEP_TALL3;
                STEP_TALL3: step_next = STEP_MAIN;
                default:    step_next = STEP_MAIN;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (cmd_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            step_reg      <= STEP_MAIN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // command register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_code_reg   <= is_main ? {1'b0, head.code_main}
                                      : {1'b0, head.code_alt} + 10'({code_add, 4'b0000});
            out_colour_reg <= head.colour;
            out_mx_reg     <= head.mirror_x;
            out_my_reg     <= head.mirror_y;
            out_x_reg      <= head.pos_x;
            out_y_reg      <= head.pos_y + CELL_H_STEP * {9'd0, y_mul};
            out_last_reg   <= is_main;
        end
    end

    assign cmd_valid = out_valid_reg;
    assign tile_code = out_code_reg;
    assign colour    = out_colour_reg;
    assign mirror_x  = out_mx_reg;
    assign mirror_y  = out_my_reg;
    assign pos_x     = out_x_reg;
    assign pos_y     = out_y_reg;
    assign last_cell = out_last_reg;

    // a sprite in progress never returns to its wide cell
    assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> step_reg != STEP_WIDE)
        else $error("sequence restarted inside a sprite");

    // a queue entry is released only with its main cell
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg && out_last_reg && !active_reg)
        else $error("entry released without its main cell");

    // a cell other than the main one keeps the sprite open
    assert property (@(posedge clk) disable iff (!rst_n)
        load && !is_main |=> active_reg && !out_last_reg)
        else $error("sprite closed before its main cell");

endmodule

@@ test/tb_top.sv @@
// testbench for the sprite attribute decoder: cell scoreboard, stimulus and handshake drivers
`timescale 1ns / 1ps

module tb_top;
    import sad_pkg::*;

    // spare register indexes, writes to them must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 59;
    localparam int TAIL_CYCLES     = 20;
    localparam int LONG_HOLD       = 120;
    localparam int MAX_PRINTED     = 50;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   sprite_valid;
    logic                   sprite_ready;
    logic [7:0]             attr_flags;
    logic [7:0]             raw_y;
    logic [7:0]             raw_code;
    logic [7:0]             raw_x;
    logic                   cmd_valid;
    logic                   cmd_ready;
    logic [9:0]             tile_code;
    logic [5:0]             colour;
    logic                   mirror_x;
    logic                   mirror_y;
    logic signed [10:0]     pos_x;
    logic signed [10:0]     pos_y;
    logic                   last_cell;

    int cycle_count   = 0;
    int long_hold     = 0;
    int setting_count = 0;
    bit sender_calm   = 1'b0;
    bit receiver_calm = 1'b0;

    // one expected draw command
    typedef struct {
        logic [9:0]  tile;
        logic [5:0]  colour;
        logic        mx;
        logic        my;
        logic [10:0] px;
        logic [10:0] py;
        logic        last;
    } draw_cell_t;

    // predicts the cells of each sprite request and checks the command stream
    class cell_scoreboard;
        // register copies start at their reset values
        bit          flip = 1'b0;
        logic [1:0]  bank = 2'd0;
        draw_cell_t  expected_cells[$];
        int          errors;
        int          sprites_seen;
        int          cells_checked;

        task report(input string msg);
            errors++;
            if (errors <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void write_reg(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SCREEN_FLIP: flip = data[0];
                REG_COLOUR_BANK: bank = data;
                default: ;
            endcase
        endfunction

        function void add_cell(input int code, input int col, input logic mx,
                               input logic my, input int x, input int y,
                               input logic last);
            draw_cell_t c;
            c.tile   = 10'(code);
            c.colour = 6'(col);
            c.mx     = mx;
            c.my     = my;
            c.px     = 11'(x);
            c.py     = 11'(y);
            c.last   = last;
            expected_cells.push_back(c);
        endfunction

        // decode one sprite entry into its cells, main cell last
        function void note_sprite(input logic [7:0] flags, input logic [7:0] ry,
                                  input logic [7:0] rc, input logic [7:0] rx);
            int   x;
            int   y;
            int   code;
            int   code2;
            int   col;
            logic mx;
            logic my;
            logic wide;
            logic tall;
            sprites_seen++;
            y     = ry ^ 8'hFF;
            x     = rx * 2 + 72;
            code  = {flags[5], rc};
            code2 = code;
            mx    = flags[7];
            my    = flags[6];
            wide  = flags[3];
            tall  = flags[4];
            col   = flags[2:1] | (((code >> 7) & 1) << 2) | (code & 8) | (bank << 4);

            // cocktail flip mirrors the position and both mirror bits
            if (flip)
            begin
                x  = 512 - CELL_WIDTH - x;
                y  = 256 - CELL_HEIGHT - y;
                if (wide)
                    y = y - CELL_HEIGHT;
                mx = !mx;
                my = !my;
            end

            // wide entry: bit 4 of the two codes set apart by the y mirror
            if (wide)
            begin
                if (my)
                begin
                    code  = code | 16;
                    code2 = code2 & ~16;
                end
                else
                begin
                    code  = code & ~16;
                    code2 = code2 | 16;
                end
                add_cell(code2, col, mx, my, x, y + CELL_HEIGHT, 1'b0);
            end

            // tall entry: three cells stacked below
            if (tall)
            begin
                for (int j = 1; j <= 3; j++)
                    add_cell(code2 + 16 * j, col, mx, my, x, y + j * CELL_HEIGHT, 1'b0);
            end

            add_cell(code, col, mx, my, x, y, 1'b1);
        endfunction

        task compare_field(input string name, input logic [10:0] got,
                           input logic [10:0] want);
            if (got !== want)
                report($sformatf("cell %0d %s is %0h, expected %0h",
                                 cells_checked, name, got, want));
        endtask

        task check_cell(input logic [9:0] t, input logic [5:0] c, input logic mx,
                        input logic my, input logic [10:0] px, input logic [10:0] py,
                        input logic lc);
            draw_cell_t want;
            if (expected_cells.size() == 0)
            begin
                report($sformatf("unexpected draw command, tile %0h", t));
                return;
            end
            want = expected_cells.pop_front();
            compare_field("tile_code", t, want.tile);
            compare_field("colour", c, want.colour);
            compare_field("mirror_x", mx, want.mx);
            compare_field("mirror_y", my, want.my);
            compare_field("pos_x", px, want.px);
            compare_field("pos_y", py, want.py);
            compare_field("last_cell", lc, want.last);
            cells_checked++;
        endtask

        task finish_check();
            if (expected_cells.size() != 0)
                report($sformatf("%0d draw commands never arrived", expected_cells.size()));
        endtask
    endclass

    cell_scoreboard sb;

    sprite_attribute_decoder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sprite_valid (sprite_valid),
        .sprite_ready (sprite_ready),
        .attr_flags   (attr_flags),
        .raw_y        (raw_y),
        .raw_code     (raw_code),
        .raw_x        (raw_x),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .tile_code    (tile_code),
        .colour       (colour),
        .mirror_x     (mirror_x),
        .mirror_y     (mirror_y),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .last_cell    (last_cell)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d draw commands outstanding",
                     cycle_count, sb.expected_cells.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // idle length: mostly none, some short, a few long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // byte with extra weight on the extremes
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return 8'h00;
        if (r == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // sample every accepted request at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (sprite_valid && sprite_ready)
                sb.note_sprite(attr_flags, raw_y, raw_code, raw_x);
            if (cmd_valid && cmd_ready)
                sb.check_cell(tile_code, colour, mirror_x, mirror_y, pos_x, pos_y,
                              last_cell);
        end
    end

    // command receiver with random stalls and an occasional long hold
    initial
    begin
        int stall_left;
        stall_left = 0;
        cmd_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                cmd_ready <= 1'b0;
            else if (long_hold > 0)
            begin
                cmd_ready <= 1'b0;
                long_hold--;
            end
            else if (stall_left > 0)
            begin
                cmd_ready <= 1'b0;
                stall_left--;
            end
            else if (!receiver_calm && $urandom_range(0, 3) == 0)
            begin
                cmd_ready  <= 1'b0;
                stall_left = idle_length();
            end
            else
                cmd_ready <= 1'b1;
        end
    end

    // one sprite request; valid stays up between back-to-back requests
    task automatic send_sprite(input logic [7:0] f, input logic [7:0] y,
                               input logic [7:0] c, input logic [7:0] x);
        int gap;
        gap = sender_calm ? 0 : idle_length();
        if (gap > 0)
        begin
            sprite_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sprite_valid <= 1'b1;
        attr_flags   <= f;
        raw_y        <= y;
        raw_code     <= c;
        raw_x        <= x;
        do @(posedge clk); while (!(sprite_valid && sprite_ready));
    endtask

    task automatic send_random_sprite();
        send_sprite(8'($urandom_range(0, 255)), pick_byte(), pick_byte(), pick_byte());
    endtask

    // one register write request
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
    endtask

    task automatic program_regs(input logic [CFG_DATA_W-1:0] flip_data,
                                input logic [CFG_DATA_W-1:0] bank_data,
                                input bit touch_spare);
        write_reg(REG_SCREEN_FLIP, flip_data);
        write_reg(REG_COLOUR_BANK, bank_data);
        if (touch_spare)
        begin
            write_reg(REG_SPARE_2, CFG_DATA_W'($urandom_range(0, 3)));
            write_reg(REG_SPARE_3, CFG_DATA_W'($urandom_range(0, 3)));
        end
        cfg_valid <= 1'b0;
        setting_count++;
    endtask

    // hold the sender until every expected command has come out
    task automatic wait_drained();
        sprite_valid <= 1'b0;
        do @(posedge clk); while (sb.expected_cells.size() != 0);
    endtask

    // main sequence
    initial
    begin
        logic [CFG_DATA_W-1:0] flip_data;
        logic [CFG_DATA_W-1:0] bank_data;
        sb = new;
        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        sprite_valid <= 1'b0;
        attr_flags   <= '0;
        raw_y        <= '0;
        raw_code     <= '0;
        raw_x        <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        setting_count = 1;

        // directed entries at reset settings
        send_sprite(8'h00, 8'h00, 8'h00, 8'h00);  // plain cell, all fields low
        send_sprite(8'hFF, 8'hFF, 8'hFF, 8'hFF);  // all bits set, wide and tall
        send_sprite(8'h08, 8'h40, 8'h10, 8'h20);  // wide, code bit 4 already set
        send_sprite(8'h48, 8'h40, 8'h0F, 8'h20);  // wide with y mirror
        send_sprite(8'h10, 8'h80, 8'h30, 8'h60);  // tall only
        send_sprite(8'h58, 8'h00, 8'hEF, 8'h80);  // wide and tall with y mirror
        send_sprite(8'h18, 8'hFF, 8'h00, 8'hFF);  // wide and tall
        send_sprite(8'h30, 8'h10, 8'hFF, 8'h00);  // code bit 8, largest tile code
        send_sprite(8'h06, 8'h22, 8'h88, 8'h11);  // all colour bits
        send_sprite(8'h01, 8'h33, 8'h44, 8'h55);  // unused flag bit
        send_sprite(8'h80, 8'h7F, 8'h77, 8'hFE);  // x mirror only
        send_sprite(8'h40, 8'h01, 8'h08, 8'h01);  // y mirror only
        wait_drained();

        // directed entries on a flipped screen, top colour bank
        program_regs(2'b11, 2'd3, 1'b0);
        send_sprite(8'h00, 8'h00, 8'h00, 8'h00);
        send_sprite(8'h00, 8'hFF, 8'hFF, 8'hFF);  // x goes negative
        send_sprite(8'h08, 8'h00, 8'h10, 8'hFF);  // wide shifts y up a cell
        send_sprite(8'h48, 8'hFF, 8'h10, 8'h00);
        send_sprite(8'h18, 8'h80, 8'h55, 8'h80);
        send_sprite(8'hD8, 8'h00, 8'hAA, 8'h00);
        send_sprite(8'hF1, 8'hFF, 8'hFF, 8'hFF);

        // random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_drained();
            flip_data = (p == 0) ? 2'b00 : (p == 1) ? 2'b11 :
                        CFG_DATA_W'($urandom_range(0, 3));
            bank_data = (p == 0) ? 2'd0 : (p == 1) ? 2'd3 :
                        CFG_DATA_W'($urandom_range(0, 3));
            program_regs(flip_data, bank_data, p == 2);
            sender_calm   = (p == 3) || (p == 5);
            receiver_calm = (p == 3);
            // receiver holds off while the sender keeps pushing
            if (p == 5)
                long_hold = LONG_HOLD;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_sprite();
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;

        // drain and let any stray command show up
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        sb.finish_check();

        $display("covered %0d sprite requests and %0d draw commands under %0d register settings",
                 sb.sprites_seen, sb.cells_checked, setting_count);
        $display("with flipped and plain screen, all colour banks and a long output stall");
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/sad_pkg.sv
hw/rtl/sad_front.sv
hw/rtl/sad_queue.sv
hw/rtl/sad_back.sv
hw/rtl/sprite_attribute_decoder_unit.sv
test/tb_top.sv
